FILE: rtl/osd_pkg.sv
// Shared types and constants for the open-shop schedule decoder.
// No dependencies; used by every module under rtl/ except osd_ram.
`timescale 1ns / 1ps
`default_nettype none

package osd_pkg;

  localparam int NUM_JOBS     = 8;
  localparam int NUM_MACHINES = 8;

  // field widths fixed by the port list
  localparam int MACH_W = 3;
  localparam int POS_W  = 3;
  localparam int JOB_W  = 3;
  localparam int PT_W   = 10;
  localparam int TIME_W = 16;

  // every 3-bit job code keeps its own free time
  localparam int JOB_SLOTS = 1 << JOB_W;
  localparam int TOTAL     = NUM_JOBS * NUM_MACHINES;
  localparam int CNT_W     = $clog2(TOTAL + 1);
  localparam int NP_W      = $clog2(NUM_JOBS + 1);
  localparam int RAM_AW    = $clog2(NUM_JOBS);
  localparam int RAM_W     = JOB_W + PT_W;

  // load queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              wr_en;     // machine and position in range
    logic [MACH_W-1:0] machine;
    logic [POS_W-1:0]  position;
    logic [JOB_W-1:0]  job;
    logic [PT_W-1:0]   ptime;
    logic              last;
  } load_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_EVAL,
    S_PICK,
    S_COMMIT
  } sched_state_t;

endpackage

`default_nettype wire

FILE: rtl/osd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module osd_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/osd_front.sv
// Front end: takes load words, flags in-range writes, queues them for the back end.
// Depends on osd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module osd_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [osd_pkg::MACH_W-1:0] machine_index,
  input  wire logic [osd_pkg::POS_W-1:0]  order_position,
  input  wire logic [osd_pkg::JOB_W-1:0]  job_id,
  input  wire logic [osd_pkg::PT_W-1:0]   proc_time,
  input  wire logic                       load_last,
  output logic                            q_valid,
  input  wire logic                       q_ready,
  output osd_pkg::load_word_t             q_word
);

  osd_pkg::load_word_t     qmem [osd_pkg::QDEPTH];
  osd_pkg::load_word_t     word_in;
  logic [osd_pkg::QAW-1:0] wr_ptr;
  logic [osd_pkg::QAW-1:0] rd_ptr;
  logic [osd_pkg::QCW-1:0] count;
  logic                    push;
  logic                    pop;

  always_comb begin
    word_in.wr_en    = ({1'b0, machine_index} < (osd_pkg::MACH_W + 1)'(osd_pkg::NUM_MACHINES))
                    && ({1'b0, order_position} < (osd_pkg::POS_W + 1)'(osd_pkg::NUM_JOBS));
    word_in.machine  = machine_index;
    word_in.position = order_position;
    word_in.job      = job_id;
    word_in.ptime    = proc_time;
    word_in.last     = load_last;
  end

  assign in_ready = (count != osd_pkg::QCW'(osd_pkg::QDEPTH));
  assign q_valid  = (count != '0);
  assign q_word   = qmem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + osd_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + osd_pkg::QAW'(1);
      end
      if (push && !pop) begin
        count <= count + osd_pkg::QCW'(1);
      end else if (pop && !push) begin
        count <= count - osd_pkg::QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/osd_back.sv
// Back end: writes the genome rows, then runs the greedy placement and emits words.
// Depends on osd_pkg and osd_ram (one row RAM per machine).
`timescale 1ns / 1ps
`default_nettype none

module osd_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  wire osd_pkg::load_word_t        q_word,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [osd_pkg::JOB_W-1:0]       placed_job,
  output logic [osd_pkg::MACH_W-1:0]      placed_machine,
  output logic [osd_pkg::TIME_W-1:0]      start_time,
  output logic                            run_last
);

  localparam int NM = osd_pkg::NUM_MACHINES;
  localparam int TW = osd_pkg::TIME_W;

  osd_pkg::sched_state_t state, state_next;

  logic                        start_run;
  logic                        commit;
  logic                        is_last;

  logic [TW-1:0]               mfree [NM];
  logic [TW-1:0]               jfree [osd_pkg::JOB_SLOTS];
  logic [osd_pkg::NP_W-1:0]    npos [NM];
  logic [osd_pkg::NP_W-1:0]    npos_next [NM];
  logic [osd_pkg::CNT_W-1:0]   pcount;

  logic [osd_pkg::RAM_W-1:0]   rd_word [NM];
  logic [NM-1:0]               cand_valid;
  logic [TW-1:0]               cand_t [NM];

  // evaluate stage registers
  logic [NM-1:0]               ev_v;
  logic [TW-1:0]               ev_t [NM];
  logic [osd_pkg::JOB_W-1:0]   ev_j [NM];
  logic [osd_pkg::PT_W-1:0]    ev_p [NM];

  // pick stage
  logic                        best_v;
  logic [TW-1:0]               best_t;
  logic [osd_pkg::MACH_W-1:0]  best_m;
  logic [osd_pkg::JOB_W-1:0]   best_j;
  logic [osd_pkg::PT_W-1:0]    best_p;
  logic                        pick_v;
  logic [TW-1:0]               pick_t;
  logic [osd_pkg::MACH_W-1:0]  pick_m;
  logic [osd_pkg::JOB_W-1:0]   pick_j;
  logic [osd_pkg::PT_W-1:0]    pick_p;

  logic [TW:0]                 fin_sum;
  logic [TW-1:0]               fin;

  // ---------------- control ----------------
  assign is_last = (pcount == osd_pkg::CNT_W'(osd_pkg::TOTAL - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    start_run  = 1'b0;
    commit     = 1'b0;
    case (state)
      osd_pkg::S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && q_word.last) begin
          start_run  = 1'b1;
          state_next = osd_pkg::S_PRIME;
        end
      end
      // row RAMs were written last cycle; read position zero again
      osd_pkg::S_PRIME: begin
        state_next = osd_pkg::S_EVAL;
      end
      osd_pkg::S_EVAL: begin
        state_next = osd_pkg::S_PICK;
      end
      osd_pkg::S_PICK: begin
        state_next = osd_pkg::S_COMMIT;
      end
      osd_pkg::S_COMMIT: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = is_last ? osd_pkg::S_IDLE : osd_pkg::S_EVAL;
        end
      end
      default: begin
        state_next = osd_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------- row RAMs and candidates ----------------
  for (genvar m = 0; m < NM; m++) begin : g_mach
    logic                      we;
    logic [osd_pkg::JOB_W-1:0] cj;
    logic [TW-1:0]             jt;

    always_comb begin
      if (start_run) begin
        npos_next[m] = '0;
      end else if (commit && (pick_m == osd_pkg::MACH_W'(m))) begin
        npos_next[m] = npos[m] + osd_pkg::NP_W'(1);
      end else begin
        npos_next[m] = npos[m];
      end
    end

    assign we = q_valid && q_ready && q_word.wr_en
             && (q_word.machine == osd_pkg::MACH_W'(m));

    osd_ram #(
      .WIDTH (osd_pkg::RAM_W),
      .DEPTH (osd_pkg::NUM_JOBS)
    ) u_row (
      .clk   (clk),
      .we    (we),
      .waddr (q_word.position[osd_pkg::RAM_AW-1:0]),
      .wdata ({q_word.job, q_word.ptime}),
      .raddr (npos_next[m][osd_pkg::RAM_AW-1:0]),
      .rdata (rd_word[m])
    );

    assign cj            = rd_word[m][osd_pkg::RAM_W-1:osd_pkg::PT_W];
    assign jt            = jfree[cj];
    assign cand_valid[m] = (npos[m] < osd_pkg::NP_W'(osd_pkg::NUM_JOBS));
    assign cand_t[m]     = (mfree[m] > jt) ? mfree[m] : jt;

    always_ff @(posedge clk) begin
      if (state == osd_pkg::S_EVAL) begin
        ev_v[m] <= cand_valid[m];
        ev_t[m] <= cand_t[m];
        ev_j[m] <= cj;
        ev_p[m] <= rd_word[m][osd_pkg::PT_W-1:0];
      end
    end
  end

  // ---------------- pick: strict less-than keeps the lowest machine on a tie ----------------
  always_comb begin
    best_v = 1'b0;
    best_t = '0;
    best_m = '0;
    best_j = '0;
    best_p = '0;
    for (int m = 0; m < NM; m++) begin
      if (ev_v[m] && (!best_v || (ev_t[m] < best_t))) begin
        best_v = 1'b1;
        best_t = ev_t[m];
        best_m = osd_pkg::MACH_W'(m);
        best_j = ev_j[m];
        best_p = ev_p[m];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == osd_pkg::S_PICK) begin
      pick_v <= best_v;
      pick_t <= best_t;
      pick_m <= best_m;
      pick_j <= best_j;
      pick_p <= best_p;
    end
  end

  // ---------------- commit: saturating finish time ----------------
  assign fin_sum = {1'b0, pick_t} + (TW + 1)'(pick_p);
  assign fin     = fin_sum[TW] ? '1 : fin_sum[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0;
      for (int m = 0; m < NM; m++) begin
        mfree[m] <= '0;
        npos[m]  <= '0;
      end
      for (int k = 0; k < osd_pkg::JOB_SLOTS; k++) begin
        jfree[k] <= '0;
      end
    end else begin
      for (int m = 0; m < NM; m++) begin
        npos[m] <= npos_next[m];
      end
      if (start_run) begin
        pcount <= '0;
        for (int m = 0; m < NM; m++) begin
          mfree[m] <= '0;
        end
        for (int k = 0; k < osd_pkg::JOB_SLOTS; k++) begin
          jfree[k] <= '0;
        end
      end else if (commit) begin
        pcount <= pcount + osd_pkg::CNT_W'(1);
        for (int m = 0; m < NM; m++) begin
          if (pick_m == osd_pkg::MACH_W'(m)) begin
            mfree[m] <= fin;
          end
        end
        for (int k = 0; k < osd_pkg::JOB_SLOTS; k++) begin
          if (pick_j == osd_pkg::JOB_W'(k)) begin
            jfree[k] <= fin;
          end
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      placed_job     <= pick_j;
      placed_machine <= pick_m;
      start_time     <= pick_t;
      run_last       <= is_last;
    end
  end

`ifndef NO_ASSERTIONS
  // while a run is open some machine must still have a job to offer
  a_cand_avail: assert property (@(posedge clk) disable iff (rst)
    (state == osd_pkg::S_EVAL) |-> (|cand_valid))
    else $error("osd_back: evaluate with no candidate left");

  a_commit_found: assert property (@(posedge clk) disable iff (rst)
    commit |-> pick_v)
    else $error("osd_back: commit without a picked operation");

  a_loop_back: assert property (@(posedge clk) disable iff (rst)
    (commit && !is_last) |=> (state == osd_pkg::S_EVAL))
    else $error("osd_back: run ended early");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    start_run |=> ((pcount == '0) && (state == osd_pkg::S_PRIME)))
    else $error("osd_back: run start did not clear placement count");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("osd_back: placement not presented");
`endif

endmodule

`default_nettype wire

FILE: rtl/open_shop_schedule_decoder_top.sv
// Top level of the open-shop greedy schedule decoder.
// Depends on osd_pkg, osd_front, osd_back (which holds the osd_ram row memories).
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------------
//   load in | in_valid / in_ready  | machine_index, order_position, job_id, proc_time,
//           |                      | load_last
//   result  | out_valid/ out_ready | placed_job, placed_machine, start_time, run_last
//
// Load words go in at one per cycle while in_ready is high, into a two-word queue;
// the back end drains it one word per cycle while idle, writing the addressed row RAM.
// A word with load_last opens a run: a prime step, then each placement passes through
// evaluate (all machines), pick (the minimum) and commit, looping back to evaluate until
// NUM_JOBS*NUM_MACHINES placements are done.
// The registered read of the row RAMs and the eight-way minimum set that loop.
// Reset is a single cycle with no clearing pass; the genome tables keep their
// contents across runs and are undefined until loaded.
// A stalled result holds the commit step; the queue keeps taking load words until full.
`timescale 1ns / 1ps
`default_nettype none

module open_shop_schedule_decoder_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // load words
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [osd_pkg::MACH_W-1:0] machine_index,
  input  wire logic [osd_pkg::POS_W-1:0]  order_position,
  input  wire logic [osd_pkg::JOB_W-1:0]  job_id,
  input  wire logic [osd_pkg::PT_W-1:0]   proc_time,
  input  wire logic                       load_last,
  // placed operations
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [osd_pkg::JOB_W-1:0]       placed_job,
  output logic [osd_pkg::MACH_W-1:0]      placed_machine,
  output logic [osd_pkg::TIME_W-1:0]      start_time,
  output logic                            run_last
);

  // queue between front and back
  logic                q_valid;
  logic                q_ready;
  osd_pkg::load_word_t q_word;

  osd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .machine_index  (machine_index),
    .order_position (order_position),
    .job_id         (job_id),
    .proc_time      (proc_time),
    .load_last      (load_last),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_word         (q_word)
  );

  osd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_word         (q_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .placed_job     (placed_job),
    .placed_machine (placed_machine),
    .start_time     (start_time),
    .run_last       (run_last)
  );

endmodule

`default_nettype wire
